FILE: rtl/udsw_pkg.sv
// Package for the up/down hours:minutes:seconds stopwatch.
// Command codes, button indexes, time limits and the item struct types.
// No dependencies.
package udsw_pkg;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_PAUSE  = 3'd2,
    CMD_RESUME = 3'd3,
    CMD_POLL   = 3'd4
  } cmd_e;

  localparam int unsigned NUM_ADJ       = 6;
  localparam int unsigned BTN_HR_DN     = 0;
  localparam int unsigned BTN_HR_UP     = 1;
  localparam int unsigned BTN_MIN_DN    = 2;
  localparam int unsigned BTN_MIN_UP    = 3;
  localparam int unsigned BTN_SEC_DN    = 4;
  localparam int unsigned BTN_SEC_UP    = 5;
  localparam int unsigned BTN_COUNTDOWN = 6;

  localparam logic [4:0] HOUR_MAX       = 5'd23;
  localparam logic [5:0] MIN_MAX        = 6'd59;
  localparam logic [5:0] SEC_MAX        = 6'd59;
  localparam logic [7:0] DEBOUNCE_RESET = 8'd30;

  typedef struct packed {
    logic [2:0] cmd;
    logic [6:0] buttons;
  } in_item_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       counting_down;
    logic       buzzer;
    logic       running;
  } out_item_t;

endpackage

FILE: rtl/up_down_stopwatch_top.sv
// A transfer accepted into the input register moves on to the output register once the output stage is free.
// Throughput: one item per cycle while the output is not stalled; input register, single-pass update, output register.
// The input stage takes a new item while a result waits, as long as it is empty or the output frees.
// Reset (rst_ni low, async): time 00:00:00, counting up, buzzer off, running,
// lockout counters zero, debounce_polls 30, both pipeline stages empty.
// Top level of the stopwatch; depends on udsw_pkg, udsw_lockout, udsw_core.
module up_down_stopwatch_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  udsw_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output udsw_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);
  import udsw_pkg::*;

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic [7:0] debounce_q;
  logic      out_free;
  logic      adv;
  logic      poll;
  logic [NUM_ADJ-1:0] act;
  out_item_t next;

  assign out_free    = !out_valid_q || out_ready_i;
  assign adv         = in_valid_q && out_free;
  assign in_ready_o  = !in_valid_q || out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;
  assign poll        = adv && (in_q.cmd == CMD_POLL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
    end else if (cfg_valid_i) begin
      debounce_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= next;
    end
  end

  udsw_lockout u_lockout (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .poll_i     (poll),
    .buttons_i  (in_q.buttons[NUM_ADJ-1:0]),
    .debounce_i (debounce_q),
    .act_o      (act)
  );

  udsw_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .cmd_i       (in_q.cmd),
    .countdown_i (in_q.buttons[BTN_COUNTDOWN]),
    .act_i       (act),
    .next_o      (next)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) adv |=> out_valid_q)
    else $error("advanced item lost before output register");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_valid_q && !out_free |=> in_valid_q && $stable(in_q))
    else $error("held input stage changed while output stalled");

endmodule

FILE: rtl/udsw_lockout.sv
// Per-button debounce lockout counters for the six adjust buttons.
// Depends on udsw_pkg.
module udsw_lockout (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        poll_i,
  input  logic [udsw_pkg::NUM_ADJ-1:0] buttons_i,
  input  logic [7:0]                  debounce_i,
  output logic [udsw_pkg::NUM_ADJ-1:0] act_o
);
  import udsw_pkg::*;

  logic [7:0] lock_q [NUM_ADJ];
  logic [7:0] lock_d [NUM_ADJ];

  always_comb begin
    for (int i = 0; i < NUM_ADJ; i++) begin
      act_o[i]  = poll_i && buttons_i[i] && (lock_q[i] == 8'd0);
      lock_d[i] = lock_q[i];
      if (poll_i) begin
        if (act_o[i]) begin
          lock_d[i] = (debounce_i == 8'd0) ? 8'd0 : debounce_i - 8'd1;
        end else if (lock_q[i] != 8'd0) begin
          lock_d[i] = lock_q[i] - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ADJ; i++) begin
        lock_q[i] <= 8'd0;
      end
    end else begin
      for (int i = 0; i < NUM_ADJ; i++) begin
        lock_q[i] <= lock_d[i];
      end
    end
  end

endmodule

FILE: rtl/udsw_core.sv
// Stopwatch state registers and the single-pass next-state logic.
// Depends on udsw_pkg; adjust enables come from udsw_lockout.
module udsw_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [2:0]                  cmd_i,
  input  logic                        countdown_i,
  input  logic [udsw_pkg::NUM_ADJ-1:0] act_i,
  output udsw_pkg::out_item_t         next_o
);
  import udsw_pkg::*;

  logic [4:0] hours_q, hours_d;
  logic [5:0] minutes_q, minutes_d;
  logic [5:0] seconds_q, seconds_d;
  logic       down_q, down_d;
  logic       buzzer_q, buzzer_d;
  logic       run_q, run_d;

  always_comb begin
    hours_d   = hours_q;
    minutes_d = minutes_q;
    seconds_d = seconds_q;
    down_d    = down_q;
    buzzer_d  = buzzer_q;
    run_d     = run_q;
    unique case (cmd_i)
      CMD_TICK: begin
        if (run_q) begin
          if (down_q) begin
            if (seconds_q != 6'd0) begin
              seconds_d = seconds_q - 6'd1;
            end else if (minutes_q != 6'd0) begin
              seconds_d = SEC_MAX;
              minutes_d = minutes_q - 6'd1;
            end else if (hours_q != 5'd0) begin
              seconds_d = SEC_MAX;
              minutes_d = MIN_MAX;
              hours_d   = hours_q - 5'd1;
            end else begin
              buzzer_d = 1'b1;
            end
          end else if (seconds_q != SEC_MAX) begin
            seconds_d = seconds_q + 6'd1;
          end else if (minutes_q != MIN_MAX) begin
            seconds_d = 6'd0;
            minutes_d = minutes_q + 6'd1;
          end else if (hours_q != HOUR_MAX) begin
            seconds_d = 6'd0;
            minutes_d = 6'd0;
            hours_d   = hours_q + 5'd1;
          end else begin
            // rollover past 23:59:59 clears the watch
            seconds_d = 6'd0;
            minutes_d = 6'd0;
            hours_d   = 5'd0;
            down_d    = 1'b0;
            buzzer_d  = 1'b0;
          end
        end
      end
      CMD_CLEAR: begin
        seconds_d = 6'd0;
        minutes_d = 6'd0;
        hours_d   = 5'd0;
        down_d    = 1'b0;
        buzzer_d  = 1'b0;
      end
      CMD_PAUSE:  run_d = 1'b0;
      CMD_RESUME: run_d = 1'b1;
      CMD_POLL: begin
        if (countdown_i) begin
          down_d = 1'b1;
        end
        // adjusts apply in button order
        if (act_i[BTN_HR_DN] && hours_d != 5'd0) begin
          hours_d = hours_d - 5'd1;
        end
        if (act_i[BTN_HR_UP] && hours_d != HOUR_MAX) begin
          hours_d = hours_d + 5'd1;
        end
        if (act_i[BTN_MIN_DN]) begin
          minutes_d = (minutes_d == 6'd0) ? MIN_MAX : minutes_d - 6'd1;
        end
        if (act_i[BTN_MIN_UP]) begin
          minutes_d = (minutes_d == MIN_MAX) ? 6'd0 : minutes_d + 6'd1;
        end
        if (act_i[BTN_SEC_DN]) begin
          seconds_d = (seconds_d == 6'd0) ? SEC_MAX : seconds_d - 6'd1;
        end
        if (act_i[BTN_SEC_UP]) begin
          seconds_d = (seconds_d == SEC_MAX) ? 6'd0 : seconds_d + 6'd1;
        end
      end
      default: ;
    endcase
  end

  assign next_o = '{hours: hours_d, minutes: minutes_d, seconds: seconds_d,
                    counting_down: down_d, buzzer: buzzer_d, running: run_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hours_q   <= 5'd0;
      minutes_q <= 6'd0;
      seconds_q <= 6'd0;
      down_q    <= 1'b0;
      buzzer_q  <= 1'b0;
      run_q     <= 1'b1;
    end else if (en_i) begin
      hours_q   <= hours_d;
      minutes_q <= minutes_d;
      seconds_q <= seconds_d;
      down_q    <= down_d;
      buzzer_q  <= buzzer_d;
      run_q     <= run_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) hours_q <= HOUR_MAX)
    else $error("hours out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   minutes_q <= MIN_MAX && seconds_q <= SEC_MAX)
    else $error("minutes or seconds out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) buzzer_q |-> down_q)
    else $error("buzzer set outside down mode");

endmodule

FILE: dv/stopwatch_checker.sv
// Checker for the up/down stopwatch: watches the command, result and register channels.
// Keeps its own copy of the watch state, predicts each reading and compares it field by field.
// Depends on udsw_pkg.
`timescale 1ns / 100ps

module stopwatch_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  udsw_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  udsw_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [7:0]          cfg_data_i,
  output int                  err_count_o,
  output int                  pending_o
);
  import udsw_pkg::*;

  logic [4:0] hr;
  logic [5:0] mn;
  logic [5:0] sc;
  logic       down;
  logic       buzz;
  logic       run;
  logic [7:0] lockout [NUM_ADJ];
  logic [7:0] debounce;

  out_item_t expected_readings [$];

  task automatic log_error(input string msg);
    $display("[%0t] checker: %s", $realtime, msg);
    err_count_o++;
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want);
    if (got != want) begin
      log_error($sformatf("%s: got %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic clear_time();
    hr   = '0;
    mn   = '0;
    sc   = '0;
    down = 1'b0;
    buzz = 1'b0;
  endtask

  task automatic advance_watch(input in_item_t it, output out_item_t res);
    case (it.cmd)
      CMD_TICK: begin
        if (run && down) begin
          if (sc != 0) begin
            sc = sc - 6'd1;
          end else if (mn != 0) begin
            sc = SEC_MAX;
            mn = mn - 6'd1;
          end else if (hr != 0) begin
            sc = SEC_MAX;
            mn = MIN_MAX;
            hr = hr - 5'd1;
          end else begin
            buzz = 1'b1;
          end
        end else if (run) begin
          if (sc < SEC_MAX) begin
            sc = sc + 6'd1;
          end else begin
            sc = '0;
            if (mn < MIN_MAX) begin
              mn = mn + 6'd1;
            end else begin
              mn = '0;
              // rolling past 23:59:59 clears the whole watch
              if (hr < HOUR_MAX) hr = hr + 5'd1;
              else clear_time();
            end
          end
        end
      end
      CMD_CLEAR:  clear_time();
      CMD_PAUSE:  run = 1'b0;
      CMD_RESUME: run = 1'b1;
      CMD_POLL: begin
        if (it.buttons[BTN_COUNTDOWN]) down = 1'b1;
        for (int i = 0; i < NUM_ADJ; i++) begin
          if (it.buttons[i] && lockout[i] == 0) begin
            case (i)
              BTN_HR_DN:  if (hr != 0) hr = hr - 5'd1;
              BTN_HR_UP:  if (hr < HOUR_MAX) hr = hr + 5'd1;
              BTN_MIN_DN: mn = (mn != 0) ? mn - 6'd1 : MIN_MAX;
              BTN_MIN_UP: mn = (mn < MIN_MAX) ? mn + 6'd1 : 6'd0;
              BTN_SEC_DN: sc = (sc != 0) ? sc - 6'd1 : SEC_MAX;
              default:    sc = (sc < SEC_MAX) ? sc + 6'd1 : 6'd0;
            endcase
            lockout[i] = debounce;
          end
        end
        // freshly loaded counters count down on this same poll
        for (int i = 0; i < NUM_ADJ; i++) begin
          if (lockout[i] != 0) lockout[i] = lockout[i] - 8'd1;
        end
      end
      default: ;
    endcase
    res.hours         = hr;
    res.minutes       = mn;
    res.seconds       = sc;
    res.counting_down = down;
    res.buzzer        = buzz;
    res.running       = run;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      clear_time();
      run      = 1'b1;
      debounce = DEBOUNCE_RESET;
      for (int i = 0; i < NUM_ADJ; i++) lockout[i] = '0;
      expected_readings.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          log_error("result transfer with no expected reading pending");
        end else begin
          want = expected_readings.pop_front();
          compare_field("hours", out_data_i.hours, want.hours);
          compare_field("minutes", out_data_i.minutes, want.minutes);
          compare_field("seconds", out_data_i.seconds, want.seconds);
          compare_field("counting_down", out_data_i.counting_down, want.counting_down);
          compare_field("buzzer", out_data_i.buzzer, want.buzzer);
          compare_field("running", out_data_i.running, want.running);
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_watch(in_data_i, want);
        expected_readings.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_i) debounce = cfg_data_i;
      pending_o = expected_readings.size();
    end
  end

endmodule

FILE: dv/testbench.sv
// Testbench top for up_down_stopwatch_top: clock, reset, command and register stimulus.
// Directed commands, then random command sequences over several debounce settings.
// Depends on udsw_pkg, up_down_stopwatch_top and stopwatch_checker.
`timescale 1ns / 100ps

module testbench;
  import udsw_pkg::*;

  localparam int ITEMS_PER_PHASE = 110;
  localparam int NUM_PHASES      = 8;
  localparam int HOLD_AT         = 300;
  localparam int HOLD_CYCLES     = 200;
  localparam int QUIET_FROM      = 550;
  localparam int QUIET_TO        = 700;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 4;

  localparam logic [6:0] ADJ_ALL   = (7'd1 << NUM_ADJ) - 7'd1;
  localparam logic [6:0] COUNTDOWN = 7'd1 << BTN_COUNTDOWN;
  localparam logic [6:0] HOUR_UP   = 7'd1 << BTN_HR_UP;
  localparam logic [6:0] NEAR_WRAP = HOUR_UP | (7'd1 << BTN_MIN_DN) | (7'd1 << BTN_SEC_DN);

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  int err_count;
  int pending;
  int in_count;
  int out_count;
  int cfg_count;
  int offered;
  int idle_run;
  bit hold_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  up_down_stopwatch_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  stopwatch_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // transfer counts and watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (in_valid && in_ready) in_count++;
    if (out_valid && out_ready) out_count++;
    if (cfg_valid && cfg_ready) cfg_count++;
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
    end
    if (idle_run >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit quiet_stretch();
    return in_count >= QUIET_FROM && in_count < QUIET_TO;
  endfunction

  function automatic bit take_break();
    return !quiet_stretch() && $urandom_range(0, 99) < 9;
  endfunction

  // result side: random stalls plus one long hold-off so the pipe backs up
  initial begin
    forever begin
      @(negedge clk);
      if (!hold_done && in_count >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= !take_break();
    end
  end

  task automatic offer_item(input logic [2:0] cmd, input logic [6:0] btns);
    @(negedge clk);
    if (take_break()) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{cmd: cmd, buttons: btns};
    do @(posedge clk); while (!in_ready);
    offered++;
  endtask

  task automatic write_debounce(input logic [7:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [6:0] rand_btns();
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [2:0] random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return CMD_TICK;
    if (r < 50) return CMD_CLEAR;
    if (r < 58) return CMD_PAUSE;
    if (r < 70) return CMD_RESUME;
    if (r < 95) return CMD_POLL;
    return 3'(CMD_POLL + $urandom_range(1, 3));
  endfunction

  task automatic random_sequence();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      offer_item(random_cmd(), rand_btns());
    end else if (kind < 48) begin
      offer_item(CMD_RESUME, rand_btns());
      repeat ($urandom_range(5, 70)) offer_item(CMD_TICK, rand_btns());
    end else if (kind < 62) begin
      // climb toward 23:59:59, then tick across the day boundary
      offer_item(CMD_CLEAR, rand_btns());
      offer_item(CMD_RESUME, rand_btns());
      offer_item(CMD_POLL, NEAR_WRAP);
      repeat (22) offer_item(CMD_POLL, HOUR_UP);
      repeat ($urandom_range(1, 3)) offer_item(CMD_TICK, rand_btns());
    end else if (kind < 78) begin
      offer_item(CMD_CLEAR, rand_btns());
      offer_item(CMD_RESUME, rand_btns());
      offer_item(CMD_POLL, COUNTDOWN | 7'($urandom_range(0, 63)));
      repeat ($urandom_range(1, 70)) offer_item(CMD_TICK, rand_btns());
    end else if (kind < 88) begin
      offer_item(CMD_PAUSE, rand_btns());
      repeat ($urandom_range(1, 4)) offer_item(CMD_TICK, rand_btns());
      offer_item(CMD_RESUME, rand_btns());
    end else begin
      repeat ($urandom_range(5, 20)) offer_item(CMD_POLL, rand_btns());
    end
  endtask

  initial begin
    logic [7:0] debounce_plan [6];
    logic [7:0] setting;
    debounce_plan = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd0, 8'd5};
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: every command, the lower hour saturation, wraps, pause gating, countdown to zero
    offer_item(CMD_TICK, 7'h00);
    offer_item(CMD_PAUSE, 7'h00);
    offer_item(CMD_TICK, ADJ_ALL);
    offer_item(CMD_POLL, ADJ_ALL);
    offer_item(CMD_POLL, ADJ_ALL);
    offer_item(CMD_RESUME, 7'h00);
    offer_item(CMD_TICK, 7'h7F);
    for (int c = CMD_POLL + 1; c < 8; c++) offer_item(3'(c), 7'h7F);
    offer_item(CMD_POLL, 7'h00);
    offer_item(CMD_POLL, COUNTDOWN);
    repeat (3) offer_item(CMD_TICK, 7'h00);
    offer_item(CMD_CLEAR, 7'h00);
    offer_item(CMD_POLL, COUNTDOWN);
    repeat (2) offer_item(CMD_TICK, 7'h00);
    offer_item(CMD_PAUSE, 7'h00);
    offer_item(CMD_TICK, 7'h00);
    offer_item(CMD_RESUME, 7'h00);
    offer_item(CMD_CLEAR, 7'h7F);
    offer_item(CMD_TICK, 7'h00);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      setting = (phase < 6) ? debounce_plan[phase] : 8'($urandom_range(0, 255));
      write_debounce(setting);
      while (offered < 28 + (phase + 1) * ITEMS_PER_PHASE) random_sequence();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d commands, %0d readings and %0d debounce writes",
             in_count, out_count, cfg_count);
    $display("including a %0d-cycle output hold-off and a stall-free stretch", HOLD_CYCLES);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/udsw_pkg.sv
rtl/udsw_lockout.sv
rtl/udsw_core.sv
rtl/up_down_stopwatch_top.sv
dv/stopwatch_checker.sv
dv/testbench.sv
